// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== hw/rtl/obbct_pkg.sv =====
package obbct_pkg;

  localparam int unsigned Lat = 28;

  localparam logic [2:0] REG_CENTER  = 3'd0;
  localparam logic [2:0] REG_AXIS_U  = 3'd1;
  localparam logic [2:0] REG_AXIS_V  = 3'd2;
  localparam logic [2:0] REG_AXIS_W  = 3'd3;
  localparam logic [2:0] REG_EXTENTS = 3'd4;

  localparam logic [59:0] CENTER_RST  = 60'd0;
  localparam logic [47:0] AXIS_U_RST  = 48'h0000_0000_4000;
  localparam logic [47:0] AXIS_V_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] AXIS_W_RST  = 48'h4000_0000_0000;
  localparam logic [59:0] EXTENTS_RST = {20'd4096, 20'd4096, 20'd4096};

  localparam logic [26:0] DEN_WORLD = 27'h400_0000;
  localparam logic signed [19:0] F20_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] F20_MIN = 20'sh80000;

  typedef logic signed [56:0] prod_t;

  typedef struct packed {
    logic              op;
    logic signed [19:0] in_x;
    logic signed [19:0] in_y;
    logic signed [19:0] in_z;
  } in_req_t;

  typedef struct packed {
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic signed [19:0] out_z;
    logic              inside_res;
    logic              range_error;
  } out_res_t;

  typedef struct packed {
    logic signed [59:0] num;
    logic [26:0]        den;
    logic               zero_ext;
  } div_in_t;

  typedef struct packed {
    logic signed [19:0] val;
    logic               in_box;
    logic               err;
  } div_out_t;

endpackage

// ===== hw/rtl/obbct_lane.sv =====
module obbct_lane (
  input  logic               clk_i,
  input  logic               op_i,
  input  logic signed [19:0] v_i,
  input  logic [19:0]        ext_i,
  input  logic signed [20:0] loc_i [3],
  input  logic [47:0]        axis_i,
  output obbct_pkg::prod_t   m_o [3]
);
  import obbct_pkg::*;

  logic signed [40:0] ev_q;
  logic signed [40:0] x [3];
  prod_t              m_q [3];

  always_ff @(posedge clk_i) begin
    ev_q <= $signed({1'b0, ext_i}) * v_i;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      x[j] = op_i ? ev_q : 41'(loc_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      m_q[j] <= x[j] * $signed(axis_i[16*j +: 16]);
    end
  end

  assign m_o = m_q;

endmodule

// ===== hw/rtl/obbct_merge.sv =====
module obbct_merge (
  input  logic               clk_i,
  input  logic               op_i,
  input  obbct_pkg::prod_t   m_i [3][3],
  input  logic [59:0]        center_i,
  input  logic [59:0]        ext_i,
  output obbct_pkg::div_in_t dv_o [3]
);
  import obbct_pkg::*;

  div_in_t            dv_d [3];
  div_in_t            dv_q [3];
  logic signed [19:0] c [3];
  logic [19:0]        e [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k] = $signed(center_i[20*k +: 20]);
      e[k] = ext_i[20*k +: 20];
      if (op_i) begin
        dv_d[k].num = (60'(c[k]) <<< 26) + 60'(m_i[0][k]) + 60'(m_i[1][k])
                      + 60'(m_i[2][k]);
        dv_d[k].den = DEN_WORLD;
        dv_d[k].zero_ext = 1'b0;
      end else begin
        dv_d[k].num = 60'(m_i[k][0]) + 60'(m_i[k][1]) + 60'(m_i[k][2]);
        dv_d[k].den = {5'd0, e[k], 2'b00};
        dv_d[k].zero_ext = (e[k] == 20'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  assign dv_o = dv_q;

endmodule

// ===== hw/rtl/obbct_div.sv =====
module obbct_div (
  input  logic                clk_i,
  input  obbct_pkg::div_in_t  dv_i,
  output obbct_pkg::div_out_t res_o
);
  import obbct_pkg::*;

  logic [59:0] mag1_q;
  logic [26:0] d1_q;
  logic        neg1_q, nz1_q, zero1_q;

  logic [60:0] rem_q  [22];
  logic [26:0] d_q    [22];
  logic [20:0] qb_q   [22];
  logic        neg_q  [22];
  logic        nz_q   [22];
  logic        zero_q [22];
  logic        in_q   [22];
  logic [60:0] sh     [21];
  logic        ge     [21];

  logic [19:0] qv;
  logic        sat;
  div_out_t    res_d, res_q;

  always_ff @(posedge clk_i) begin
    mag1_q  <= dv_i.num[59] ? 60'(-dv_i.num) : 60'(dv_i.num);
    neg1_q  <= dv_i.num[59];
    nz1_q   <= (dv_i.num != 60'sd0);
    d1_q    <= dv_i.den;
    zero1_q <= dv_i.zero_ext;
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= 61'(mag1_q) + 61'(d1_q >> 1);
    d_q[0]    <= d1_q;
    qb_q[0]   <= '0;
    neg_q[0]  <= neg1_q;
    nz_q[0]   <= nz1_q;
    zero_q[0] <= zero1_q;
    in_q[0]   <= !zero1_q && (mag1_q <= (60'(d1_q) << 12));
  end

  always_comb begin
    for (int i = 0; i < 21; i++) begin
      sh[i] = 61'(d_q[i]) << (20 - i);
      ge[i] = (rem_q[i] >= sh[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 21; i++) begin
      rem_q[i+1]  <= ge[i] ? rem_q[i] - sh[i] : rem_q[i];
      qb_q[i+1]   <= {qb_q[i][19:0], ge[i]};
      d_q[i+1]    <= d_q[i];
      neg_q[i+1]  <= neg_q[i];
      nz_q[i+1]   <= nz_q[i];
      zero_q[i+1] <= zero_q[i];
      in_q[i+1]   <= in_q[i];
    end
  end

  always_comb begin
    qv  = qb_q[21][19:0];
    sat = qb_q[21][20] | (!neg_q[21] & qv[19]) | (neg_q[21] & qv[19] & (|qv[18:0]));
    res_d.in_box = in_q[21];
    if (zero_q[21]) begin
      res_d.err = 1'b1;
      res_d.val = !nz_q[21] ? 20'sd0 : (neg_q[21] ? F20_MIN : F20_MAX);
    end else if (sat) begin
      res_d.err = 1'b1;
      res_d.val = neg_q[21] ? F20_MIN : F20_MAX;
    end else begin
      res_d.err = 1'b0;
      res_d.val = neg_q[21] ? $signed(-qv) : $signed(qv);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/obb_point_coordinate_transform.sv =====
// channel   | direction | handshake              | payload
// request   | in        | start / busy           | req_i (op, in_x, in_y, in_z)
// result    | out       | valid_o (one cycle)    | res_o (out_x..z, inside, error)
// config    | in/out    | APB psel/penable/pready| paddr, pwdata, prdata (64 bit)
// A request is taken every cycle; busy is never raised.
// Each result passes through three stages of multiply and merge, two of divider
// setup, 21 restoring divider stages (one quotient bit each) and two output
// registers.
// Reset clears the valid pipeline and loads the unit box; results in flight are lost.
// The receiver cannot stall; configuration is to be written while the pipeline is empty (not enforced).
module obb_point_coordinate_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  obbct_pkg::in_req_t req_i,
  output logic               valid_o,
  output obbct_pkg::out_res_t res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import obbct_pkg::*;

  `include "assert_macros.svh"

  logic [59:0] center_q, ext_q;
  logic [47:0] axis_q [3];
  logic        wr;

  logic [Lat-1:0]     valid_q;
  logic               op_q [Lat-1];
  logic signed [20:0] loc_q [3];
  logic signed [19:0] vin [3];
  prod_t              m [3][3];
  div_in_t            dv [3];
  div_out_t           dout [3];
  out_res_t           res_d, res_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RST;
      axis_q[0] <= AXIS_U_RST;
      axis_q[1] <= AXIS_V_RST;
      axis_q[2] <= AXIS_W_RST;
      ext_q <= EXTENTS_RST;
    end else if (wr) begin
      unique case (paddr[5:3])
        REG_CENTER:  center_q  <= pwdata[59:0];
        REG_AXIS_U:  axis_q[0] <= pwdata[47:0];
        REG_AXIS_V:  axis_q[1] <= pwdata[47:0];
        REG_AXIS_W:  axis_q[2] <= pwdata[47:0];
        REG_EXTENTS: ext_q     <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_CENTER:  prdata = {4'd0, center_q};
      REG_AXIS_U:  prdata = {16'd0, axis_q[0]};
      REG_AXIS_V:  prdata = {16'd0, axis_q[1]};
      REG_AXIS_W:  prdata = {16'd0, axis_q[2]};
      REG_EXTENTS: prdata = {4'd0, ext_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Lat-2:0], start & !busy};
    end
  end

  assign vin[0] = req_i.in_x;
  assign vin[1] = req_i.in_y;
  assign vin[2] = req_i.in_z;

  always_ff @(posedge clk_i) begin
    op_q[0] <= req_i.op;
    for (int s = 1; s < Lat - 1; s++) begin
      op_q[s] <= op_q[s-1];
    end
    for (int j = 0; j < 3; j++) begin
      loc_q[j] <= 21'(vin[j]) - 21'($signed(center_q[20*j +: 20]));
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    obbct_lane u_lane (
      .clk_i  (clk_i),
      .op_i   (op_q[0]),
      .v_i    (vin[k]),
      .ext_i  (ext_q[20*k +: 20]),
      .loc_i  (loc_q),
      .axis_i (axis_q[k]),
      .m_o    (m[k])
    );

    obbct_div u_div (
      .clk_i (clk_i),
      .dv_i  (dv[k]),
      .res_o (dout[k])
    );
  end

  obbct_merge u_merge (
    .clk_i    (clk_i),
    .op_i     (op_q[1]),
    .m_i      (m),
    .center_i (center_q),
    .ext_i    (ext_q),
    .dv_o     (dv)
  );

  always_comb begin
    res_d.out_x = dout[0].val;
    res_d.out_y = dout[1].val;
    res_d.out_z = dout[2].val;
    res_d.inside_res = !op_q[Lat-2] & dout[0].in_box & dout[1].in_box & dout[2].in_box;
    res_d.range_error = dout[0].err | dout[1].err | dout[2].err;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q[Lat-1];
  assign res_o   = res_q;

  `ASSERT_IMPLIES(a_valid_from_start, clk_i, rst_ni, valid_o, $past(start, Lat))
  `ASSERT_IMPLIES(a_inside_no_err, clk_i, rst_ni, valid_o && res_o.inside_res, !res_o.range_error)

endmodule
